[src/botq_pkg.sv]
// Shared types, constants and state encoding for the box overlap table query block.
`default_nettype none

package botq_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W      = 5;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
    } box_t;

    typedef struct packed {
        logic               func;
        logic [SLOT_W-1:0]  slot;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
        logic               entry_valid;
        logic               remove_hits;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              last;
    } rsp_t;

    // sequencer -> table controls
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             wr_valid;
        box_t             wr_box;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             clr_en;
        logic [IDX_W-1:0] clr_addr;
    } tbl_req_t;

    // table -> datapath read data
    typedef struct packed {
        box_t box;
        logic valid;
    } tbl_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } seq_state_t;

endpackage

`default_nettype wire

[src/botq_table.sv]
// Box table: one-write one-read memory plus per-slot valid flops.
`default_nettype none

module botq_table (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire botq_pkg::tbl_req_t ctl,
    output botq_pkg::tbl_rsp_t      rd
);

    botq_pkg::box_t                      mem [botq_pkg::TABLE_DEPTH];
    botq_pkg::box_t                      rd_box_reg;
    logic [botq_pkg::TABLE_DEPTH-1:0]    valid_reg;
    logic                                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_box;
        end
        if (ctl.rd_en)
        begin
            rd_box_reg <= mem[ctl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[ctl.wr_addr] <= ctl.wr_valid;
            end
            else if (ctl.clr_en)
            begin
                valid_reg[ctl.clr_addr] <= 1'b0;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctl.rd_addr];
            end
        end
    end

    assign rd.box   = rd_box_reg;
    assign rd.valid = rd_valid_reg;

endmodule

`default_nettype wire

[src/botq_overlap.sv]
// Shared strict-overlap compare unit: one stored box against the query box.
`default_nettype none

module botq_overlap (
    input  wire botq_pkg::box_t p,
    input  wire botq_pkg::box_t q,
    output logic                hit
);

    logic signed [16:0] p_left, p_top, q_left, q_top;
    logic signed [16:0] p_right, p_bottom, q_right, q_bottom;

    always_comb
    begin
        p_left   = 17'(p.left);
        p_top    = 17'(p.top);
        q_left   = 17'(q.left);
        q_top    = 17'(q.top);
        // 17-bit signed sums are exact
        p_right  = p_left + $signed({2'b00, p.width});
        p_bottom = p_top  + $signed({2'b00, p.height});
        q_right  = q_left + $signed({2'b00, q.width});
        q_bottom = q_top  + $signed({2'b00, q.height});
        hit = (p_left < q_right) && (p_right > q_left) &&
              (p_top < q_bottom) && (p_bottom > q_top);
    end

endmodule

`default_nettype wire

[src/botq_seq.sv]
// Sequencer: item intake, slot walk, pending-hit hold and result register.
`default_nettype none

module botq_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire botq_pkg::req_t     req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output botq_pkg::rsp_t          rsp,
    output botq_pkg::tbl_req_t      tbl_ctl,
    input  wire botq_pkg::tbl_rsp_t tbl_rd,
    input  wire logic               ovl_hit,
    output botq_pkg::box_t          qbox
);

    botq_pkg::seq_state_t               state_reg, state_next;
    botq_pkg::box_t                     qbox_reg, qbox_next;
    logic                               remove_reg, remove_next;
    logic [botq_pkg::CNT_W-1:0]         addr_reg, addr_next;
    logic                               s1_vld_reg, s1_vld_next;
    logic [botq_pkg::IDX_W-1:0]         s1_idx_reg, s1_idx_next;
    logic                               pend_vld_reg, pend_vld_next;
    logic [botq_pkg::SLOT_W-1:0]        pend_slot_reg, pend_slot_next;
    logic                               out_vld_reg, out_vld_next;
    botq_pkg::rsp_t                     out_reg, out_next;

    logic is_hit, out_free, stall, addr_more, scan_done;
    botq_pkg::box_t req_box;

    assign req_box.left   = req.left;
    assign req_box.top    = req.top;
    assign req_box.width  = req.width;
    assign req_box.height = req.height;

    assign is_hit    = s1_vld_reg && tbl_rd.valid && ovl_hit;
    assign out_free  = !out_vld_reg || rsp_ready;
    assign stall     = is_hit && pend_vld_reg && !out_free;
    assign addr_more = addr_reg < botq_pkg::CNT_W'(botq_pkg::TABLE_DEPTH);
    assign scan_done = !addr_more && !s1_vld_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            botq_pkg::ST_IDLE:
            begin
                if (req_valid && req.func == botq_pkg::FUNC_QUERY)
                begin
                    state_next = botq_pkg::ST_SCAN;
                end
            end
            botq_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = botq_pkg::ST_FLUSH;
                end
            end
            botq_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = botq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = botq_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        qbox_next      = qbox_reg;
        remove_next    = remove_reg;
        addr_next      = addr_reg;
        s1_vld_next    = s1_vld_reg;
        s1_idx_next    = s1_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        out_vld_next   = out_vld_reg;
        out_next       = out_reg;
        req_ready      = (state_reg == botq_pkg::ST_IDLE);

        tbl_ctl          = '0;
        tbl_ctl.wr_addr  = botq_pkg::IDX_W'(req.slot);
        tbl_ctl.wr_valid = req.entry_valid;
        tbl_ctl.wr_box   = req_box;
        tbl_ctl.rd_addr  = addr_reg[botq_pkg::IDX_W-1:0];
        tbl_ctl.clr_addr = s1_idx_reg;

        if (out_vld_reg && rsp_ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            botq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.func == botq_pkg::FUNC_QUERY)
                    begin
                        qbox_next     = req_box;
                        remove_next   = req.remove_hits;
                        addr_next     = '0;
                        s1_vld_next   = 1'b0;
                        pend_vld_next = 1'b0;
                    end
                    else
                    begin
                        // slots beyond the table are dropped
                        tbl_ctl.wr_en = (32'(req.slot) < 32'(botq_pkg::TABLE_DEPTH));
                    end
                end
            end
            botq_pkg::ST_SCAN:
            begin
                if (!stall)
                begin
                    if (is_hit)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_vld_next      = 1'b1;
                            out_next.hit      = 1'b1;
                            out_next.hit_slot = pend_slot_reg;
                            out_next.last     = 1'b0;
                        end
                        pend_vld_next  = 1'b1;
                        pend_slot_next = botq_pkg::SLOT_W'(s1_idx_reg);
                        tbl_ctl.clr_en = remove_reg;
                    end
                    if (addr_more)
                    begin
                        tbl_ctl.rd_en = 1'b1;
                        s1_vld_next   = 1'b1;
                        s1_idx_next   = addr_reg[botq_pkg::IDX_W-1:0];
                        addr_next     = addr_reg + 1'b1;
                    end
                    else
                    begin
                        s1_vld_next = 1'b0;
                    end
                end
            end
            botq_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_vld_next      = 1'b1;
                    out_next.hit      = pend_vld_reg;
                    out_next.hit_slot = pend_vld_reg ? pend_slot_reg : '0;
                    out_next.last     = 1'b1;
                    pend_vld_next     = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= botq_pkg::ST_IDLE;
            s1_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            addr_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_vld_reg   <= s1_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            addr_reg     <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qbox_reg      <= qbox_next;
        remove_reg    <= remove_next;
        s1_idx_reg    <= s1_idx_next;
        pend_slot_reg <= pend_slot_next;
        out_reg       <= out_next;
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;
    assign qbox      = qbox_reg;

`ifndef NO_ASSERTIONS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == botq_pkg::ST_IDLE |-> !pend_vld_reg && !s1_vld_reg)
        else $error("pending hit or compare left over in idle");

    a_nohit_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_reg.hit |-> out_reg.last && out_reg.hit_slot == '0)
        else $error("no-hit result not marked last");

    a_flush_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == botq_pkg::ST_FLUSH |->
            addr_reg == botq_pkg::CNT_W'(botq_pkg::TABLE_DEPTH))
        else $error("flush before all slots walked");

    a_clear_only_on_remove: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_ctl.clr_en |-> remove_reg && is_hit)
        else $error("valid bit cleared without a removing hit");

    a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> !tbl_ctl.rd_en ##1 s1_vld_reg && $stable(s1_idx_reg))
        else $error("compare stage moved during a result stall");
`endif

endmodule

`default_nettype wire

[src/box_overlap_table_query_top.sv]
// Top level of the box overlap table query block.
//
// Usage:
//   req channel (req_valid/req_ready/req): one item is either a table write
//   (func = write) or a query (func = query). A write stores the box in the
//   named slot and sets its valid bit from entry_valid; it gives no result.
//   A write to a slot beyond the table is dropped.
//   rsp channel (rsp_valid/rsp_ready/rsp): a query gives one result per
//   overlapping valid slot in slot order, the final one with last set; a
//   query with no overlap gives a single result with hit clear and last set.
//   With remove_hits set, every hit slot loses its valid bit.
// Timing:
//   A query walks every slot through one shared compare unit, one slot per
//   cycle behind a registered table read while no stall holds it; then a
//   flush step sends the final result and ready returns. A hit is held
//   pending until another hit or the end of the walk sends it to the
//   result register. req_ready is high only while no query is walking.
// Stalls: a hit ready to leave while the result register is still held
//   freezes the walk until the receiver takes the waiting result.
// Reset: all valid bits clear at once; box contents are undefined until written.
`default_nettype none

module box_overlap_table_query_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire botq_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output botq_pkg::rsp_t      rsp
);

    botq_pkg::tbl_req_t tbl_ctl;  // sequencer commands to the table
    botq_pkg::tbl_rsp_t tbl_rd;   // registered table read data
    botq_pkg::box_t     qbox;     // captured query box
    logic               ovl_hit;  // compare unit verdict for the slot in flight

    botq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .tbl_ctl   (tbl_ctl),
        .tbl_rd    (tbl_rd),
        .ovl_hit   (ovl_hit),
        .qbox      (qbox)
    );

    botq_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tbl_ctl),
        .rd    (tbl_rd)
    );

    // single compare unit reused for every slot of the walk
    botq_overlap u_overlap (
        .p   (tbl_rd.box),
        .q   (qbox),
        .hit (ovl_hit)
    );

endmodule

`default_nettype wire
